### sv/assert_macros.svh
// assertion macros shared by the lexer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising clock edge outside reset
`define CTL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form: when ante holds, cons must hold in the same cycle
`define CTL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/ctl_pkg.sv
// types, constants and lexer mode codes for the token lexer
`timescale 1ns / 1ps

package ctl_pkg;

  localparam int unsigned MAX_TOKEN_BYTES = 4096;
  localparam int unsigned TOK_LEN_W       = $clog2(MAX_TOKEN_BYTES + 1);
  localparam int unsigned LINE_W          = 24;
  localparam int unsigned MAX_RESULTS     = 3;
  localparam int unsigned CNT_W           = $clog2(MAX_RESULTS + 1);

  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  // lexer mode codes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_WORD    = 3'd1;
  localparam logic [2:0] MODE_EQUALS  = 3'd2;
  localparam logic [2:0] MODE_STRING  = 3'd3;
  localparam logic [2:0] MODE_SLASH   = 3'd4;
  localparam logic [2:0] MODE_COMMENT = 3'd5;
  localparam logic [2:0] MODE_CSTAR   = 3'd6;
  localparam logic [2:0] MODE_PENDING = 3'd7;

  // result kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic              item_kind;
    logic [7:0]        token_char;
    logic [LINE_W-1:0] line_number;
    logic              last_of_step;
  } out_item_t;

  typedef struct packed {
    logic [2:0]           mode;
    logic                 quote_is_double;
    logic                 escape_active;
    logic [LINE_W-1:0]    line_count;
    logic [TOK_LEN_W-1:0] token_length;
  } lex_state_t;

  typedef struct packed {
    out_item_t [MAX_RESULTS-1:0] items;
    logic [CNT_W-1:0]            count;
  } step_res_t;

  localparam lex_state_t LEX_RESET = '{
    mode:            MODE_IDLE,
    quote_is_double: 1'b0,
    escape_active:   1'b0,
    line_count:      LINE_W'(1),
    token_length:    '0
  };

endpackage

### sv/ctl_step.sv
// next lexer state and result list for one source byte
`timescale 1ns / 1ps

module ctl_step (
  input  ctl_pkg::lex_state_t state_i,
  input  ctl_pkg::in_item_t   item_i,
  output ctl_pkg::lex_state_t state_o,
  output ctl_pkg::step_res_t  res_o
);
  import ctl_pkg::*;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  localparam logic [TOK_LEN_W-1:0] TOK_LIMIT = TOK_LEN_W'(MAX_TOKEN_BYTES);

  function automatic logic is_word(input logic [7:0] c);
    is_word = c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], 8'h5F};
  endfunction

  lex_state_t                  st;
  logic [7:0]                  c;
  logic [7:0]                  quote_ch;
  logic                        mid_v;     // byte inside the open token
  logic [7:0]                  mid_ch;
  logic                        close_v;   // end marker
  logic                        do_start;  // current byte opens a new token
  logic                        start_v;   // start byte is emitted
  logic [LINE_W-1:0]           close_line;
  logic [CNT_W-1:0]            n;
  out_item_t [MAX_RESULTS-1:0] items;

  always_comb begin
    st         = state_i;
    c          = item_i.text_byte;
    quote_ch   = state_i.quote_is_double ? CH_DQ : CH_SQ;
    mid_v      = 1'b0;
    mid_ch     = c;
    close_v    = 1'b0;
    do_start   = 1'b0;
    start_v    = 1'b0;

    if (item_i.end_of_text) begin
      case (state_i.mode)
        MODE_WORD, MODE_EQUALS, MODE_STRING, MODE_PENDING: begin
          close_v = 1'b1;
        end
        MODE_SLASH: begin
          mid_v   = 1'b1;
          mid_ch  = CH_SLASH;
          close_v = 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      if (c == CH_NL && st.line_count < LINE_MAX) begin
        st.line_count = st.line_count + LINE_W'(1);
      end
      case (state_i.mode)
        MODE_WORD: begin
          if (is_word(c)) begin
            mid_v = (st.token_length < TOK_LIMIT);
          end else begin
            close_v  = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_EQUALS: begin
          if (c == CH_EQ) begin
            mid_v = (st.token_length < TOK_LIMIT);
          end else begin
            close_v  = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_STRING: begin
          if (!st.escape_active && c == quote_ch) begin
            st.escape_active = 1'b0;
            st.mode          = MODE_PENDING;
          end else begin
            mid_v            = (st.token_length < TOK_LIMIT);
            st.escape_active = !st.escape_active && c == CH_BSL;
          end
        end
        MODE_SLASH: begin
          if (c == CH_STAR) begin
            st.mode = MODE_COMMENT;
          end else begin
            // held slash goes out as a one-byte token
            mid_v    = 1'b1;
            mid_ch   = CH_SLASH;
            close_v  = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (c == CH_STAR) begin
            st.mode = MODE_CSTAR;
          end
        end
        MODE_CSTAR: begin
          if (c == CH_SLASH) begin
            st.mode = MODE_IDLE;
          end else if (c != CH_STAR) begin
            st.mode = MODE_COMMENT;
          end
        end
        MODE_PENDING: begin
          close_v  = 1'b1;
          do_start = 1'b1;
        end
        default: begin
          do_start = 1'b1;
        end
      endcase
    end

    // a held slash always lands, since the token restarts at zero length
    if (mid_v) begin
      st.token_length = st.token_length + TOK_LEN_W'(1);
    end

    close_line = st.line_count;
    if (close_v) begin
      st.token_length  = '0;
      st.mode          = MODE_IDLE;
      st.escape_active = 1'b0;
    end

    if (do_start) begin
      st.token_length  = '0;
      st.escape_active = 1'b0;
      if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
        st.mode = MODE_IDLE;
      end else if (is_word(c)) begin
        start_v = 1'b1;
        st.mode = MODE_WORD;
      end else if (c == CH_EQ) begin
        start_v = 1'b1;
        st.mode = MODE_EQUALS;
      end else if (c == CH_SQ || c == CH_DQ) begin
        start_v            = 1'b1;
        st.quote_is_double = (c == CH_DQ);
        st.mode            = MODE_STRING;
      end else if (c == CH_SLASH) begin
        st.mode = MODE_SLASH;
      end else begin
        start_v = 1'b1;
        st.mode = MODE_PENDING;
      end
      if (start_v) begin
        st.token_length = TOK_LEN_W'(1);
      end
    end

    if (item_i.end_of_text) begin
      st = LEX_RESET;
    end

    // pack results in emission order
    items = '0;
    n     = '0;
    if (mid_v) begin
      items[n[1:0]].item_kind  = KIND_BYTE;
      items[n[1:0]].token_char = mid_ch;
      n = n + CNT_W'(1);
    end
    if (close_v) begin
      items[n[1:0]].item_kind   = KIND_END;
      items[n[1:0]].line_number = close_line;
      n = n + CNT_W'(1);
    end
    if (start_v) begin
      items[n[1:0]].item_kind  = KIND_BYTE;
      items[n[1:0]].token_char = c;
      n = n + CNT_W'(1);
    end
    if (n != '0) begin
      items[2'(n - CNT_W'(1))].last_of_step = 1'b1;
    end
  end

  assign state_o     = st;
  assign res_o.items = items;
  assign res_o.count = n;

endmodule

### sv/c_subset_token_lexer_unit.sv
// top level of the streaming c-subset token lexer
// an accepted item is registered in inr_q; its results are registered in items_q once the result queue is free
// throughput: one item per cycle while each item gives at most one result and out_stall_i is low
// an item with k results (k up to 3) holds the result queue until all k results are taken
// reset clears handshake state and lexer state, line counter back to 1
`timescale 1ns / 1ps
`include "assert_macros.svh"

module c_subset_token_lexer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ctl_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ctl_pkg::out_item_t out_item_o
);
  import ctl_pkg::*;

  logic                        inr_valid_q;
  in_item_t                    inr_q;
  lex_state_t                  lex_q;
  lex_state_t                  lex_d;
  step_res_t                   res;
  out_item_t [MAX_RESULTS-1:0] items_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        out_take;
  logic                        list_free;
  logic                        advance;
  logic                        in_take;

  ctl_step u_step (
    .state_i (lex_q),
    .item_i  (inr_q),
    .state_o (lex_d),
    .res_o   (res)
  );

  assign out_take   = (cnt_q != '0) && !out_stall_i;
  assign list_free  = (cnt_q == '0) || (cnt_q == CNT_W'(1) && out_take);
  assign advance    = inr_valid_q && list_free;
  assign in_stall_o = inr_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = items_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inr_valid_q <= 1'b0;
      lex_q       <= LEX_RESET;
      cnt_q       <= '0;
    end else begin
      if (in_take) begin
        inr_valid_q <= 1'b1;
      end else if (advance) begin
        inr_valid_q <= 1'b0;
      end
      if (advance) begin
        lex_q <= lex_d;
        cnt_q <= res.count;
      end else if (out_take) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      inr_q <= in_item_i;
    end
    if (advance) begin
      items_q <= res.items;
    end else if (out_take) begin
      // result queue moves up by one item
      items_q[0] <= items_q[1];
      items_q[1] <= items_q[2];
    end
  end

  `CTL_ASSERT(a_cnt_range, cnt_q <= CNT_W'(MAX_RESULTS), "result count out of range")
  `CTL_ASSERT_IMP(a_last_flag, out_valid_o,
                  out_item_o.last_of_step == (cnt_q == CNT_W'(1)), "last flag misplaced")
  `CTL_ASSERT_IMP(a_end_marker, out_valid_o && out_item_o.item_kind == KIND_END,
                  out_item_o.token_char == 8'h00 && out_item_o.line_number != '0,
                  "malformed end marker")
  `CTL_ASSERT_IMP(a_byte_line, out_valid_o && out_item_o.item_kind == KIND_BYTE,
                  out_item_o.line_number == '0, "token byte carries a line number")
  `CTL_ASSERT(a_tok_len, lex_q.token_length <= TOK_LEN_W'(MAX_TOKEN_BYTES),
              "token length beyond limit")

endmodule
